### rtl/slwbc_pkg.sv
// package: shared types and constants for the split lru write-back cache model
package slwbc_pkg;

    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 32;
    localparam int CNT_W    = 32;
    localparam int OFF_W    = 3;
    localparam int IDX_W    = 4;
    localparam int WAYS_W   = 4;

    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FETCH = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    localparam logic [1:0] REG_OFFSET = 2'd0;
    localparam logic [1:0] REG_INDEX  = 2'd1;
    localparam logic [1:0] REG_WAYS   = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic             dirty_eviction;
        logic [CNT_W-1:0] data_misses;
        logic [CNT_W-1:0] inst_misses;
        logic [CNT_W-1:0] write_backs;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_OUT
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + CNT_W'(1);
    endfunction

endpackage

### rtl/slwbc_if.sv
// interface: valid/ready channel carrying one item
interface slwbc_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/split_lru_writeback_cache_model_core.sv
// top level: split instruction/data set-associative lru write-back cache model
// For each access the set row is read from a synchronous memory (all ways of one set
// in one word, one word per cache side), then all ways are compared and the updated
// row is written back. A new item is taken only once the previous result has entered
// the output register. Kind 3 makes no access. Tag, valid, dirty and rank of every
// way live in the memory row. After reset a clearing pass zeroes every row of both
// memories; the input is not ready until it is done.
module split_lru_writeback_cache_model_core #(
    parameter int MAX_SETS  = 1024,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    slwbc_if.sink       in_ch,
    slwbc_if.source     out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import slwbc_pkg::*;

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int MAX_IB = $clog2(MAX_SETS + 1) - 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TAG_W  = ADDR_W;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [WAY_W-1:0] rank;
        logic             dirty;
        logic             valid;
    } line_t;

    typedef line_t [MAX_WAYS-1:0] row_t;

    logic [OFF_W-1:0]  offset_bits_reg;
    logic [IDX_W-1:0]  index_bits_reg;
    logic [WAYS_W-1:0] ways_used_reg;

    row_t imem [MAX_SETS];
    row_t dmem [MAX_SETS];
    row_t irow_reg, drow_reg;

    state_t state_reg, state_next;
    logic [KIND_W-1:0] kind_reg;
    logic [TAG_W-1:0]  block_reg;
    logic [SET_W-1:0]  set_reg;
    logic [WAYS_W:0]   ways_reg;
    logic [CNT_W-1:0] dmiss_reg, imiss_reg, wb_reg;
    logic hit_reg, evict_reg;
    rsp_t out_reg;
    logic out_valid_reg;
    logic clr_active_reg;
    logic [SET_W-1:0] clr_idx_reg;

    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_OFFSET: prdata = 32'(offset_bits_reg);
            REG_INDEX:  prdata = 32'(index_bits_reg);
            REG_WAYS:   prdata = 32'(ways_used_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFF_W'(4);
            index_bits_reg  <= IDX_W'(6);
            ways_used_reg   <= WAYS_W'(1);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_OFFSET: offset_bits_reg <= pwdata[OFF_W-1:0];
                REG_INDEX:  index_bits_reg  <= pwdata[IDX_W-1:0];
                REG_WAYS:   ways_used_reg   <= pwdata[WAYS_W-1:0];
                default:    ;
            endcase
        end
    end

    // geometry for the incoming item
    logic [IDX_W-1:0] ib_eff;
    logic [WAYS_W:0]  ways_eff;
    logic [ADDR_W-1:0] addr_m, block_in;
    logic [SET_W-1:0] set_in;
    logic in_fire;

    always_comb
    begin
        ib_eff = (32'(index_bits_reg) > MAX_IB) ? IDX_W'(MAX_IB) : index_bits_reg;
        if (ways_used_reg == '0)
            ways_eff = (WAYS_W+1)'(1);
        else if (32'(ways_used_reg) > MAX_WAYS)
            ways_eff = (WAYS_W+1)'(MAX_WAYS);
        else
            ways_eff = (WAYS_W+1)'(ways_used_reg);
        addr_m = (ADDR_BITS >= ADDR_W) ? in_ch.payload.address
               : (in_ch.payload.address & ADDR_W'((64'(1) << ADDR_BITS) - 64'(1)));
        block_in = addr_m >> offset_bits_reg;
        set_in = SET_W'(block_in & ((ADDR_W'(1) << ib_eff) - ADDR_W'(1)));
    end

    assign in_ch.ready = (state_reg == ST_IDLE) && !clr_active_reg;
    assign in_fire = in_ch.valid && in_ch.ready;

    // compare, victim choice and rank update
    row_t  row, row_new;
    logic [MAX_WAYS-1:0] inuse, hitv;
    logic is_data, hit, found_inv, evict;
    logic [WAY_W-1:0] used, inv_w, lru_w, best;
    logic [WAY_W:0] old_rank;

    always_comb
    begin
        is_data = (kind_reg == KIND_READ) || (kind_reg == KIND_WRITE);
        row = is_data ? drow_reg : irow_reg;
        hit = 1'b0; used = '0; found_inv = 1'b0; inv_w = '0; lru_w = '0; best = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            inuse[w] = (w < 32'(ways_reg));
            hitv[w] = inuse[w] && row[w].valid && (row[w].tag == block_reg);
        end
        for (int w = MAX_WAYS-1; w >= 0; w--)
        begin
            if (hitv[w]) begin hit = 1'b1; used = WAY_W'(w); end
            if (inuse[w] && !row[w].valid) begin found_inv = 1'b1; inv_w = WAY_W'(w); end
        end
        for (int w = 0; w < MAX_WAYS; w++)
            if (inuse[w] && (w == 0 || row[w].rank > best))
            begin
                best = row[w].rank; lru_w = WAY_W'(w);
            end
        if (!hit)
            used = found_inv ? inv_w : lru_w;
        old_rank = (!hit && found_inv) ? '1 : {1'b0, row[used].rank};
        evict = is_data && !hit && row[used].valid && row[used].dirty;
        row_new = row;
        for (int w = 0; w < MAX_WAYS; w++)
            if (w != 32'(used) && inuse[w] && row[w].valid
                && {1'b0, row[w].rank} < old_rank && 32'(row[w].rank) < MAX_WAYS-1)
                row_new[w].rank = row[w].rank + WAY_W'(1);
        row_new[used].rank = '0;
        row_new[used].valid = 1'b1;
        if (!hit)
        begin
            row_new[used].tag = block_reg;
            row_new[used].dirty = (kind_reg == KIND_WRITE);
        end
        else if (kind_reg == KIND_WRITE)
            row_new[used].dirty = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            irow_reg <= imem[set_in];
            drow_reg <= dmem[set_in];
        end
        if (clr_active_reg)
        begin
            imem[clr_idx_reg] <= '0;
            dmem[clr_idx_reg] <= '0;
        end
        else if (state_reg == ST_LOOKUP && kind_reg != KIND_NONE)
        begin
            if (is_data) dmem[set_reg] <= row_new;
            else         imem[set_reg] <= row_new;
        end
        if (in_fire)
        begin
            kind_reg  <= in_ch.payload.kind;
            block_reg <= block_in;
            set_reg   <= set_in;
            ways_reg  <= ways_eff;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_fire) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_OUT;
            ST_OUT:    if (!out_valid_reg || out_ch.ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dmiss_reg <= '0; imiss_reg <= '0; wb_reg <= '0;
            hit_reg <= 1'b0; evict_reg <= 1'b0;
            out_reg <= '0;
            out_valid_reg <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_active_reg)
            begin
                if (clr_idx_reg == SET_W'(MAX_SETS - 1))
                    clr_active_reg <= 1'b0;
                else
                    clr_idx_reg <= clr_idx_reg + SET_W'(1);
            end
            if (state_reg == ST_LOOKUP)
            begin
                hit_reg <= (kind_reg != KIND_NONE) && hit;
                evict_reg <= evict;
                if (is_data)
                begin
                    if (!hit) dmiss_reg <= sat_inc(dmiss_reg);
                    if (evict) wb_reg <= sat_inc(wb_reg);
                end
                else if (kind_reg == KIND_FETCH)
                begin
                    if (!hit) imiss_reg <= sat_inc(imiss_reg);
                end
            end
            if (state_reg == ST_OUT && (!out_valid_reg || out_ch.ready))
            begin
                out_valid_reg <= 1'b1;
                out_reg.hit <= hit_reg;
                out_reg.dirty_eviction <= evict_reg;
                out_reg.data_misses <= dmiss_reg;
                out_reg.inst_misses <= imiss_reg;
                out_reg.write_backs <= wb_reg;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;

endmodule

### test/tb.sv
// testbench for the split lru write-back cache model core
`timescale 1ns / 100ps

module tb;
    import slwbc_pkg::*;

    localparam int N_SETS = 1024;
    localparam int N_WAYS = 8;
    localparam int SIDE_D = 0;
    localparam int SIDE_I = 1;

    typedef struct {
        req_t req;
        bit   typed;
        rsp_t rsp;
    } drow_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    slwbc_if #(.T(req_t)) in_ch ();
    slwbc_if #(.T(rsp_t)) out_ch ();

    split_lru_writeback_cache_model_core dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // cache mirror
    bit [31:0] m_tag   [2][N_SETS][N_WAYS];
    bit        m_valid [2][N_SETS][N_WAYS];
    bit        m_dirty [N_SETS][N_WAYS];
    bit [2:0]  m_rank  [2][N_SETS][N_WAYS];
    bit [31:0] cnt_dmiss, cnt_imiss, cnt_wb;
    bit [2:0]  cfg_off;
    bit [3:0]  cfg_idx;
    bit [3:0]  cfg_ways;

    rsp_t exp_rsp_q[$];
    int   errors = 0;
    int   send_idle = 0;
    int   recv_idle = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic bit [31:0] sat_up(input bit [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    task automatic promote(input int sd, input int st, input int ways, input int used,
                           input int old_rank);
        for (int w = 0; w < ways; w++)
            if (w != used && m_valid[sd][st][w] && m_rank[sd][st][w] < old_rank
                && m_rank[sd][st][w] < N_WAYS - 1)
                m_rank[sd][st][w]++;
        m_rank[sd][st][used] = 0;
    endtask

    task automatic lookup_set(input int sd, input int st, input int ways, input bit [31:0] blk,
                              input bit is_wr, output bit hit, output bit evict);
        int  victim;
        int  best;
        bit  found;
        victim = 0;
        best = 0;
        found = 0;
        hit = 0;
        evict = 0;
        for (int w = 0; w < ways; w++)
            if (!hit && m_valid[sd][st][w] && m_tag[sd][st][w] == blk)
            begin
                hit = 1;
                promote(sd, st, ways, w, m_rank[sd][st][w]);
                if (sd == SIDE_D && is_wr)
                    m_dirty[st][w] = 1;
            end
        if (hit)
            return;
        for (int w = 0; w < ways; w++)
            if (!found && !m_valid[sd][st][w])
            begin
                victim = w;
                found = 1;
            end
        if (!found)
            for (int w = 0; w < ways; w++)
                if (w == 0 || m_rank[sd][st][w] > best)
                begin
                    best = m_rank[sd][st][w];
                    victim = w;
                end
        if (sd == SIDE_D && m_valid[sd][st][victim] && m_dirty[st][victim])
            evict = 1;
        promote(sd, st, ways, victim, found ? 32'h7FFF_FFFF : int'(m_rank[sd][st][victim]));
        m_valid[sd][st][victim] = 1;
        m_tag[sd][st][victim] = blk;
        if (sd == SIDE_D)
            m_dirty[st][victim] = is_wr;
    endtask

    task automatic predict_access(input req_t r, output rsp_t p);
        int        ib;
        int        ways;
        bit [31:0] blk;
        int        st;
        bit        hit;
        bit        evict;
        ib = cfg_idx;
        ways = cfg_ways;
        hit = 0;
        evict = 0;
        while (ib > 0 && (1 << ib) > N_SETS)
            ib--;
        if (ways == 0)
            ways = 1;
        if (ways > N_WAYS)
            ways = N_WAYS;
        blk = r.address >> cfg_off;
        st = int'(blk & ((32'd1 << ib) - 1));
        if (r.kind == KIND_READ || r.kind == KIND_WRITE)
        begin
            lookup_set(SIDE_D, st, ways, blk, r.kind == KIND_WRITE, hit, evict);
            if (!hit)
                cnt_dmiss = sat_up(cnt_dmiss);
            if (evict)
                cnt_wb = sat_up(cnt_wb);
        end
        else if (r.kind == KIND_FETCH)
        begin
            lookup_set(SIDE_I, st, ways, blk, 1'b0, hit, evict);
            if (!hit)
                cnt_imiss = sat_up(cnt_imiss);
        end
        p.hit = hit;
        p.dirty_eviction = evict;
        p.data_misses = cnt_dmiss;
        p.inst_misses = cnt_imiss;
        p.write_backs = cnt_wb;
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_OFFSET: cfg_off = val[2:0];
            REG_INDEX:  cfg_idx = val[3:0];
            default:    cfg_ways = val[3:0];
        endcase
    endtask

    task automatic wait_drained();
        while (exp_rsp_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_item(input req_t r, input bit typed, input rsp_t want);
        rsp_t p;
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= r;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_access(r, p);
        exp_rsp_q.push_back(typed ? want : p);
    endtask

    always @(posedge clk)
    begin
        rsp_t e;
        if (out_ch.valid && out_ch.ready)
        begin
            if (exp_rsp_q.size() == 0)
                report("unexpected item", 32'd0, 32'd0);
            else
            begin
                e = exp_rsp_q.pop_front();
                if (out_ch.payload.hit !== e.hit)
                    report("hit", 32'(out_ch.payload.hit), 32'(e.hit));
                if (out_ch.payload.dirty_eviction !== e.dirty_eviction)
                    report("dirty_eviction", 32'(out_ch.payload.dirty_eviction),
                           32'(e.dirty_eviction));
                if (out_ch.payload.data_misses !== e.data_misses)
                    report("data_misses", out_ch.payload.data_misses, e.data_misses);
                if (out_ch.payload.inst_misses !== e.inst_misses)
                    report("inst_misses", out_ch.payload.inst_misses, e.inst_misses);
                if (out_ch.payload.write_backs !== e.write_backs)
                    report("write_backs", out_ch.payload.write_backs, e.write_backs);
            end
        end
        if (rst_n)
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        drow_t     rows[$];
        drow_t     d;
        req_t      r;
        rsp_t      none;
        bit [31:0] hi[6];
        bit [31:0] lo[4];
        int        sent;
        int        cfgs[6][3];

        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        none = '0;
        cfg_off = 3'd4;
        cfg_idx = 4'd6;
        cfg_ways = 4'd1;
        cnt_dmiss = 0;
        cnt_imiss = 0;
        cnt_wb = 0;
        cfgs = '{'{0, 0, 1}, '{7, 15, 15}, '{4, 10, 8}, '{6, 0, 0}, '{5, 2, 2}, '{4, 1, 8}};

        // directed table, geometry at reset
        rows.push_back('{'{KIND_READ,  32'h0000_0000}, 1, '{0, 0, 1, 0, 0}});
        rows.push_back('{'{KIND_WRITE, 32'h0000_0000}, 1, '{1, 0, 1, 0, 0}});
        rows.push_back('{'{KIND_WRITE, 32'h0000_0400}, 1, '{0, 1, 2, 0, 1}});
        rows.push_back('{'{KIND_FETCH, 32'hFFFF_FFFF}, 1, '{0, 0, 2, 1, 1}});
        rows.push_back('{'{KIND_NONE,  32'hFFFF_FFFF}, 1, '{0, 0, 2, 1, 1}});
        rows.push_back('{'{KIND_FETCH, 32'hFFFF_FFF0}, 0, none});
        rows.push_back('{'{KIND_READ,  32'hFFFF_FFFF}, 0, none});
        rows.push_back('{'{KIND_WRITE, 32'hFFFF_FFF8}, 0, none});
        rows.push_back('{'{KIND_READ,  32'h0000_0400}, 0, none});
        rows.push_back('{'{KIND_READ,  32'h0000_0000}, 0, none});
        rows.push_back('{'{KIND_NONE,  32'h0000_0000}, 0, none});
        rows.push_back('{'{KIND_FETCH, 32'h0000_0000}, 0, none});
        rows.push_back('{'{KIND_FETCH, 32'h0000_0400}, 0, none});
        rows.push_back('{'{KIND_WRITE, 32'hAAAA_5555}, 0, none});
        rows.push_back('{'{KIND_WRITE, 32'h5555_AAAA}, 0, none});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        send_idle = 37;
        recv_idle = 55;

        foreach (rows[i])
        begin
            d = rows[i];
            send_item(d.req, d.typed, d.rsp);
        end
        in_ch.valid <= 1'b0;
        wait_drained();

        sent = 0;
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph < 6)
            begin
                reg_write(REG_OFFSET, cfgs[ph][0]);
                reg_write(REG_INDEX, cfgs[ph][1]);
                reg_write(REG_WAYS, cfgs[ph][2]);
            end
            else
            begin
                reg_write(REG_OFFSET, $urandom);
                reg_write(REG_INDEX, $urandom);
                reg_write(REG_WAYS, $urandom);
            end
            foreach (hi[j])
                hi[j] = $urandom & 32'hFFFE_0000;
            foreach (lo[j])
                lo[j] = $urandom & 32'h0001_FFFF;
            for (int k = 0; k < 154; k++)
            begin
                if (sent == 617)
                begin
                    send_idle = 55;
                    recv_idle = 37;
                end
                if (sent == 1234)
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
                r.kind = ($urandom_range(19) == 0) ? KIND_NONE : 2'($urandom_range(2));
                if ($urandom_range(9) < 7)
                    r.address = hi[$urandom_range(5)] ^ lo[$urandom_range(3)];
                else
                    r.address = $urandom;
                send_item(r, 1'b0, none);
                sent++;
                // hold the sender until the core has drained once per phase
                if (k == 77)
                begin
                    in_ch.valid <= 1'b0;
                    while (exp_rsp_q.size() != 0)
                        @(posedge clk);
                end
            end
            in_ch.valid <= 1'b0;
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (exp_rsp_q.size() != 0)
            report("items left over", 32'(exp_rsp_q.size()), 32'd0);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
rtl/slwbc_pkg.sv
rtl/slwbc_if.sv
rtl/split_lru_writeback_cache_model_core.sv
test/tb.sv
